@@ sv/cfs_pkg.sv @@
// Package for the CSV field splitter.
// Holds the byte type, the quote and separator constants, the register map
// and the whitespace classifier. It depends on nothing else.
package cfs_pkg;

   typedef logic [7:0] byte_type;

   localparam byte_type QUOTE_BYTE = 8'h22;
   localparam byte_type SEP_RESET  = 8'h2C;

   // Register map of the configuration port.
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_SEP_ADDR = 2'd0;

   // Whitespace is 0x09..0x0D, space, NEL and no-break space.
   function automatic logic is_ws(input byte_type c);
      logic ws;
      ws = ((c >= 8'h09) && (c <= 8'h0D)) || (c == 8'h20) || (c == 8'h85) || (c == 8'hA0);
      return ws;
   endfunction

endpackage

@@ sv/cfs_space_ram.sv @@
// Whitespace run store of the CSV field splitter.
// One write port and one read port; the read data is registered and holds
// while no read is issued. Depends on cfs_pkg.
module cfs_space_ram #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  cfs_pkg::byte_type wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output cfs_pkg::byte_type rd_data
);
   import cfs_pkg::*;

   byte_type mem [DEPTH];
   byte_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/csv_field_splitter.sv @@
// CSV field splitter, top level.
// Holds the parse state, the result sequencer and the output register;
// instantiates cfs_space_ram and depends on cfs_pkg.
//
// Usage: the req channel takes one byte of a line per transaction: tdata is
// the byte, tuser says the byte is valid, tlast marks the last transaction
// of the line. The rsp channel returns field bytes, field ends and the line
// end, one per transaction, with tlast on the last result of a line.
// The separator byte is set through the csr port (address 0, reset ',').
// A byte that causes results keeps req_tready low while the sequencer
// sends them, one result per cycle unless the receiver stalls, through the
// single output register, reading held whitespace from the store's one
// read port. A flush of a whitespace run plus a field end can reach
// SPACE_RUN_MAX + 3 results.
// Reset returns the separator to ',' and starts a fresh field out of quotes;
// the whitespace store needs no clearing, it is only read below its count.
// When the receiver stalls, the result waits in the output register and the
// sequencer holds; req_tready stays low until all results of the current
// byte have been loaded into the output register.
module csv_field_splitter #(
   parameter int SPACE_RUN_MAX = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   // Input byte stream.
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] in_char
   input  logic                           req_tuser,   // [0] has_char
   input  logic                           req_tlast,   // line_last
   // Result stream.
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [15:0]                    rsp_tdata,   // [7:0] out_char, [8] space_overflow
   output logic [1:0]                     rsp_tuser,   // [0] char_valid, [1] field_end
   output logic                           rsp_tlast,   // line_end
   // Configuration port.
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [cfs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [cfs_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [cfs_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import cfs_pkg::*;

   localparam int AW = (SPACE_RUN_MAX > 1) ? $clog2(SPACE_RUN_MAX) : 1;
   localparam int CW = $clog2(SPACE_RUN_MAX + 1);
   localparam logic [CW-1:0] CNT_MAX = CW'(SPACE_RUN_MAX);
   localparam logic [CW-1:0] CNT_ONE = CW'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FLUSH_HELD,
      ST_FLUSH_SPACE,
      ST_FIN_HELD,
      ST_FIN_END,
      ST_LINE_ONLY
   } state_type;

   // Control and parse state.
   state_type      state_ff, state_in;
   byte_type       sep_ff;
   logic           iq_ff, iq_in;
   logic           qp_ff, qp_in;
   logic           at_ff, at_in;
   logic           op_ff, op_in;
   logic           rn_ff, rn_in;
   logic           hv_ff, hv_in;
   byte_type       hb_ff, hb_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           ov_ff, ov_in;

   // Snapshot of the results owed for the accepted byte.
   byte_type       fl_byte_ff, fl_byte_in;
   logic           fl_ov_ff, fl_ov_in;
   logic [CW-1:0]  fl_cnt_ff, fl_cnt_in;
   logic [CW-1:0]  rd_idx_ff, rd_idx_in;
   logic           fin_ff, fin_in;
   logic           fin_held_ff, fin_held_in;
   byte_type       fin_byte_ff, fin_byte_in;
   logic           fin_ov_ff, fin_ov_in;
   logic           last_ff, last_in;

   // Output register.
   logic           rsp_valid_ff, rsp_valid_in;
   byte_type       rsp_char_ff, rsp_char_in;
   logic           rsp_cv_ff, rsp_cv_in;
   logic           rsp_fe_ff, rsp_fe_in;
   logic           rsp_le_ff, rsp_le_in;
   logic           rsp_ov_ff, rsp_ov_in;

   // Store ports.
   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   logic           rd_en;
   logic [AW-1:0]  rd_addr;
   byte_type       rd_data;

   logic           accept;
   logic           out_free;
   logic           csr_wr;
   logic [CW-1:0]  rd_next;

   // Byte decode signals.
   byte_type       c;
   logic           skip;
   logic           feed;
   logic           do_flush;
   logic           sep_fin;
   logic           line_fin;
   logic           sel_hv;
   byte_type       sel_hb;
   logic           sel_op;
   logic           sel_ov;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rd_next    = rd_idx_ff + CNT_ONE;
   assign c          = req_tdata;

   // First field-end state once the flush is done.
   function automatic state_type fin_state(input logic fin, input logic held);
      state_type s;
      if (!fin) begin
         s = ST_IDLE;
      end else if (held) begin
         s = ST_FIN_HELD;
      end else begin
         s = ST_FIN_END;
      end
      return s;
   endfunction

   // Parse of the accepted byte and the line end.
   always_comb begin
      iq_in    = iq_ff;
      qp_in    = qp_ff;
      at_in    = at_ff;
      op_in    = op_ff;
      rn_in    = rn_ff;
      hv_in    = hv_ff;
      hb_in    = hb_ff;
      cnt_in   = cnt_ff;
      ov_in    = ov_ff;
      skip     = 1'b0;
      feed     = 1'b0;
      do_flush = 1'b0;
      sep_fin  = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = cnt_ff[AW-1:0];

      // Quote handling and separator detection.
      if (accept && req_tuser) begin
         if (qp_ff) begin
            qp_in = 1'b0;
            if (c == QUOTE_BYTE) begin
               skip = 1'b1;
            end else begin
               iq_in = 1'b0;
            end
         end
         if (!skip) begin
            if (iq_in) begin
               if (c == QUOTE_BYTE) begin
                  qp_in = 1'b1;
               end
               feed = 1'b1;
            end else if (c == sep_ff) begin
               sep_fin = 1'b1;
            end else begin
               if (c == QUOTE_BYTE) begin
                  iq_in = 1'b1;
               end
               feed = 1'b1;
            end
         end
      end

      // Trimming: skip leading whitespace, hold inner runs and the last byte.
      if (feed) begin
         rn_in = 1'b1;
         if (is_ws(c)) begin
            if (!at_ff) begin
               if (cnt_ff < CNT_MAX) begin
                  wr_en  = 1'b1;
                  cnt_in = cnt_ff + CNT_ONE;
               end else begin
                  ov_in = 1'b1;
               end
            end
         end else if (at_ff) begin
            at_in = 1'b0;
            if (c == QUOTE_BYTE) begin
               op_in = 1'b1;
            end else begin
               hb_in = c;
               hv_in = 1'b1;
            end
         end else begin
            do_flush = 1'b1;
            cnt_in   = '0;
            hb_in    = c;
            hv_in    = 1'b1;
         end
      end

      // A separator finishes the field as it stood; a line end as it stands now.
      line_fin = accept && req_tlast && rn_in && !sep_fin;
      if (sep_fin) begin
         sel_hv = hv_ff;
         sel_hb = hb_ff;
         sel_op = op_ff;
         sel_ov = ov_ff;
      end else begin
         sel_hv = hv_in;
         sel_hb = hb_in;
         sel_op = op_in;
         sel_ov = ov_in;
      end

      // Clear the field after it is finished or at any line end.
      if (sep_fin || (accept && req_tlast)) begin
         at_in  = 1'b1;
         op_in  = 1'b0;
         rn_in  = 1'b0;
         hv_in  = 1'b0;
         hb_in  = '0;
         cnt_in = '0;
         ov_in  = 1'b0;
      end
      if (accept && req_tlast) begin
         iq_in = 1'b0;
         qp_in = 1'b0;
      end
   end

   // Result sequencer and output register.
   always_comb begin
      state_in     = state_ff;
      fl_byte_in   = fl_byte_ff;
      fl_ov_in     = fl_ov_ff;
      fl_cnt_in    = fl_cnt_ff;
      rd_idx_in    = rd_idx_ff;
      fin_in       = fin_ff;
      fin_held_in  = fin_held_ff;
      fin_byte_in  = fin_byte_ff;
      fin_ov_in    = fin_ov_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_char_in  = rsp_char_ff;
      rsp_cv_in    = rsp_cv_ff;
      rsp_fe_in    = rsp_fe_ff;
      rsp_le_in    = rsp_le_ff;
      rsp_ov_in    = rsp_ov_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               fl_byte_in  = hb_ff;
               fl_ov_in    = ov_ff;
               fl_cnt_in   = do_flush ? cnt_ff : '0;
               rd_idx_in   = '0;
               fin_in      = sep_fin || line_fin;
               fin_held_in = sel_hv && !(sel_op && (sel_hb == QUOTE_BYTE));
               fin_byte_in = sel_hb;
               fin_ov_in   = sel_ov;
               last_in     = req_tlast;
               // Prefetch the first held whitespace byte.
               rd_en       = do_flush && (cnt_ff != '0);
               if (do_flush && hv_ff) begin
                  state_in = ST_FLUSH_HELD;
               end else if (do_flush && (cnt_ff != '0)) begin
                  state_in = ST_FLUSH_SPACE;
               end else if (sep_fin || line_fin) begin
                  state_in = fin_state(1'b1,
                                       sel_hv && !(sel_op && (sel_hb == QUOTE_BYTE)));
               end else if (req_tlast) begin
                  state_in = ST_LINE_ONLY;
               end
            end
         end
         ST_FLUSH_HELD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = fl_byte_ff;
               rsp_cv_in    = 1'b1;
               rsp_fe_in    = 1'b0;
               rsp_le_in    = 1'b0;
               rsp_ov_in    = fl_ov_ff;
               if (fl_cnt_ff != '0) begin
                  state_in = ST_FLUSH_SPACE;
               end else begin
                  state_in = fin_state(fin_ff, fin_held_ff);
               end
            end
         end
         ST_FLUSH_SPACE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = rd_data;
               rsp_cv_in    = 1'b1;
               rsp_fe_in    = 1'b0;
               rsp_le_in    = 1'b0;
               rsp_ov_in    = fl_ov_ff;
               rd_idx_in    = rd_next;
               if (rd_next < fl_cnt_ff) begin
                  rd_en   = 1'b1;
                  rd_addr = rd_next[AW-1:0];
               end else begin
                  state_in = fin_state(fin_ff, fin_held_ff);
               end
            end
         end
         ST_FIN_HELD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = fin_byte_ff;
               rsp_cv_in    = 1'b1;
               rsp_fe_in    = 1'b0;
               rsp_le_in    = 1'b0;
               rsp_ov_in    = fin_ov_ff;
               state_in     = ST_FIN_END;
            end
         end
         ST_FIN_END: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = '0;
               rsp_cv_in    = 1'b0;
               rsp_fe_in    = 1'b1;
               rsp_le_in    = last_ff;
               rsp_ov_in    = fin_ov_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_LINE_ONLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = '0;
               rsp_cv_in    = 1'b0;
               rsp_fe_in    = 1'b0;
               rsp_le_in    = 1'b1;
               rsp_ov_in    = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, parse registers and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iq_ff        <= 1'b0;
         qp_ff        <= 1'b0;
         at_ff        <= 1'b1;
         op_ff        <= 1'b0;
         rn_ff        <= 1'b0;
         hv_ff        <= 1'b0;
         hb_ff        <= '0;
         cnt_ff       <= '0;
         ov_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iq_ff        <= iq_in;
         qp_ff        <= qp_in;
         at_ff        <= at_in;
         op_ff        <= op_in;
         rn_ff        <= rn_in;
         hv_ff        <= hv_in;
         hb_ff        <= hb_in;
         cnt_ff       <= cnt_in;
         ov_ff        <= ov_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fl_byte_ff  <= fl_byte_in;
      fl_ov_ff    <= fl_ov_in;
      fl_cnt_ff   <= fl_cnt_in;
      rd_idx_ff   <= rd_idx_in;
      fin_ff      <= fin_in;
      fin_held_ff <= fin_held_in;
      fin_byte_ff <= fin_byte_in;
      fin_ov_ff   <= fin_ov_in;
      last_ff     <= last_in;
      rsp_char_ff <= rsp_char_in;
      rsp_cv_ff   <= rsp_cv_in;
      rsp_fe_ff   <= rsp_fe_in;
      rsp_le_ff   <= rsp_le_in;
      rsp_ov_ff   <= rsp_ov_in;
   end

   // Separator register behind the configuration port.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_ff <= SEP_RESET;
      end else if (csr_wr && (csr_paddr == CSR_SEP_ADDR)) begin
         sep_ff <= csr_pwdata[7:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == CSR_SEP_ADDR) begin
         csr_prdata = {{(CSR_DATA_W - 8){1'b0}}, sep_ff};
      end
   end

   // Whitespace run store.
   cfs_space_ram #(
      .DEPTH (SPACE_RUN_MAX),
      .AW    (AW)
   ) u_space_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (c),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Result channel.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_ov_ff, rsp_char_ff};
   assign rsp_tuser  = {rsp_fe_ff, rsp_cv_ff};
   assign rsp_tlast  = rsp_le_ff;

endmodule
